@@ design/obp_pkg.sv @@
// Package for the online bin packing placer: shared codes and small control structs.
// No dependencies; every other design file imports it.
`default_nettype none

package obp_pkg;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_NEXT  = 2'd2
    } fit_mode_t;

    localparam logic [1:0] STATUS_PLACED  = 2'd0;
    localparam logic [1:0] STATUS_TOO_BIG = 2'd1;
    localparam logic [1:0] STATUS_NO_BIN  = 2'd2;

    localparam logic [7:0] CFG_BIN_CAPACITY = 8'd0;
    localparam logic [7:0] CFG_FIT_MODE     = 8'd1;

    localparam logic [15:0] CAPACITY_RESET = 16'd100;
    localparam logic [1:0]  FIT_MODE_RESET = 2'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic valid;
        logic found;
    } tok_t;

    typedef struct packed {
        logic en;
        logic open_bin;
    } cmd_t;

endpackage

`default_nettype wire

@@ design/obp_cell.sv @@
// One bin of the placer chain: residual space, in-use flag and one stage of the search token.
// Depends on obp_pkg.
`default_nettype none

module obp_cell
    import obp_pkg::*;
#(
    parameter int CELL_IDX   = 0,
    parameter int SIZE_WIDTH = 16,
    parameter int IDX_W      = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [1:0]            mode,
    input  wire logic                  clear,
    input  wire logic [IDX_W-1:0]      current_bin,
    input  wire logic [SIZE_WIDTH-1:0] size,
    input  wire cmd_t                  cmd,
    input  wire logic [IDX_W-1:0]      cmd_idx,
    input  wire logic [SIZE_WIDTH-1:0] cmd_value,
    input  wire tok_t                  tok_in,
    input  wire logic [SIZE_WIDTH-1:0] left_in,
    input  wire logic [IDX_W-1:0]      idx_in,
    output tok_t                       tok_out,
    output logic [SIZE_WIDTH-1:0]      left_out,
    output logic [IDX_W-1:0]           idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [SIZE_WIDTH-1:0] res_reg;
    logic [SIZE_WIDTH-1:0] res_next;
    logic                  used_reg;
    logic                  used_next;
    tok_t                  tok_reg;
    tok_t                  tok_next;
    logic [SIZE_WIDTH-1:0] left_reg;
    logic [SIZE_WIDTH-1:0] left_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;

    logic                  fits;
    logic                  take;
    logic [SIZE_WIDTH-1:0] left;
    logic                  hit;

    always_comb
    begin
        fits = used_reg && (res_reg >= size);
        left = res_reg - size;
        case (mode)
            FIT_BEST:
            begin
                take = fits && (!tok_in.found || (left < left_in));
            end
            FIT_NEXT:
            begin
                take = fits && (current_bin == MY_IDX);
            end
            default:
            begin
                take = fits && !tok_in.found;
            end
        endcase

        tok_next.valid = tok_in.valid;
        if (take)
        begin
            tok_next.found = 1'b1;
            left_next      = left;
            idx_next       = MY_IDX;
        end
        else
        begin
            tok_next.found = tok_in.found;
            left_next      = left_in;
            idx_next       = idx_in;
        end

        hit       = cmd.en && (cmd_idx == MY_IDX);
        used_next = used_reg;
        res_next  = res_reg;
        if (clear)
        begin
            used_next = 1'b0;
        end
        else if (hit && cmd.open_bin)
        begin
            used_next = 1'b1;
            res_next  = cmd_value;
        end
        else if (hit)
        begin
            res_next = res_reg - cmd_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        left_reg <= left_next;
        idx_reg  <= idx_next;
    end

    assign tok_out  = tok_reg;
    assign left_out = left_reg;
    assign idx_out  = idx_reg;

endmodule

`default_nettype wire

@@ design/obp_ctrl.sv @@
// Controller of the placer: configuration registers, item intake, placement decision,
// bin update command and result register. Depends on obp_pkg.
`default_nettype none

module obp_ctrl
    import obp_pkg::*;
#(
    parameter int MAX_BINS   = 256,
    parameter int SIZE_WIDTH = 16,
    parameter int IDX_W      = 8,
    parameter int BIU_W      = 9
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [7:0]            cfg_index,
    input  wire logic [15:0]           cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [15:0]           item_size,
    input  wire logic                  first_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [15:0]                item_number,
    output logic [7:0]                 bin_index,
    output logic                       opened_bin,
    output logic [1:0]                 status,
    output logic [1:0]                 mode,
    output logic                       clear,
    output logic [IDX_W-1:0]           current_bin,
    output logic [SIZE_WIDTH-1:0]      size,
    output tok_t                       launch,
    output cmd_t                       cmd,
    output logic [IDX_W-1:0]           cmd_idx,
    output logic [SIZE_WIDTH-1:0]      cmd_value,
    input  wire tok_t                  chain_tok,
    input  wire logic [IDX_W-1:0]      chain_idx
);

    ctrl_state_t           state_reg;
    ctrl_state_t           state_next;
    logic [15:0]           cap_reg;
    logic [15:0]           cap_next;
    logic [1:0]            mode_reg;
    logic [1:0]            mode_next;
    logic [SIZE_WIDTH-1:0] size_reg;
    logic [SIZE_WIDTH-1:0] size_next;
    logic                  too_big_reg;
    logic                  too_big_next;
    logic [15:0]           number_reg;
    logic [15:0]           number_next;
    logic [15:0]           counter_reg;
    logic [15:0]           counter_next;
    logic [BIU_W-1:0]      biu_reg;
    logic [BIU_W-1:0]      biu_next;
    logic [IDX_W-1:0]      cur_reg;
    logic [IDX_W-1:0]      cur_next;
    logic                  launch_reg;
    logic                  launch_next;
    logic [7:0]            pend_bin_reg;
    logic [7:0]            pend_bin_next;
    logic                  pend_open_reg;
    logic                  pend_open_next;
    logic [1:0]            pend_status_reg;
    logic [1:0]            pend_status_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [15:0]           out_number_reg;
    logic [15:0]           out_number_next;
    logic [7:0]            out_bin_reg;
    logic [7:0]            out_bin_next;
    logic                  out_open_reg;
    logic                  out_open_next;
    logic [1:0]            out_status_reg;
    logic [1:0]            out_status_next;

    logic                  in_fire;
    logic                  decide;
    logic                  out_free;
    logic                  load_out;
    logic [SIZE_WIDTH-1:0] cap_sw;
    logic [SIZE_WIDTH-1:0] size_in;
    logic [15:0]           number_in;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (chain_tok.valid)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        decide   = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_SCAN:
            begin
                decide = chain_tok.valid;
            end
            S_DONE:
            begin
                load_out = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        in_fire   = in_valid && in_ready;
        cap_sw    = SIZE_WIDTH'(cap_reg);
        size_in   = SIZE_WIDTH'(item_size);
        number_in = first_item ? 16'd0 : counter_reg;

        cap_next  = cap_reg;
        mode_next = mode_reg;
        if (cfg_valid && (cfg_index == CFG_BIN_CAPACITY))
        begin
            cap_next = cfg_data;
        end
        if (cfg_valid && (cfg_index == CFG_FIT_MODE))
        begin
            mode_next = cfg_data[1:0];
        end

        size_next    = size_reg;
        too_big_next = too_big_reg;
        number_next  = number_reg;
        counter_next = counter_reg;
        biu_next     = biu_reg;
        cur_next     = cur_reg;
        launch_next  = 1'b0;
        clear        = 1'b0;
        if (in_fire)
        begin
            size_next    = size_in;
            too_big_next = size_in > cap_sw;
            number_next  = number_in;
            counter_next = number_in + 16'd1;
            launch_next  = 1'b1;
            clear        = first_item;
            if (first_item)
            begin
                biu_next = '0;
                cur_next = '0;
            end
        end

        cmd              = '0;
        cmd_idx          = chain_idx;
        cmd_value        = size_reg;
        pend_bin_next    = pend_bin_reg;
        pend_open_next   = pend_open_reg;
        pend_status_next = pend_status_reg;
        if (decide)
        begin
            pend_bin_next    = 8'd0;
            pend_open_next   = 1'b0;
            pend_status_next = STATUS_PLACED;
            if (too_big_reg)
            begin
                pend_status_next = STATUS_TOO_BIG;
            end
            else if (chain_tok.found)
            begin
                cmd.en        = 1'b1;
                pend_bin_next = 8'(chain_idx);
            end
            else if (biu_reg == BIU_W'(MAX_BINS))
            begin
                pend_status_next = STATUS_NO_BIN;
            end
            else
            begin
                cmd.en         = 1'b1;
                cmd.open_bin   = 1'b1;
                cmd_idx        = biu_reg[IDX_W-1:0];
                cmd_value      = cap_sw - size_reg;
                pend_bin_next  = 8'(biu_reg[IDX_W-1:0]);
                pend_open_next = 1'b1;
                biu_next       = biu_reg + BIU_W'(1);
                if (mode_reg == FIT_NEXT)
                begin
                    cur_next = biu_reg[IDX_W-1:0];
                end
            end
        end

        out_valid_next  = out_valid_reg && !out_ready;
        out_number_next = out_number_reg;
        out_bin_next    = out_bin_reg;
        out_open_next   = out_open_reg;
        out_status_next = out_status_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_number_next = number_reg;
            out_bin_next    = pend_bin_reg;
            out_open_next   = pend_open_reg;
            out_status_next = pend_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAPACITY_RESET;
            mode_reg      <= FIT_MODE_RESET;
            counter_reg   <= '0;
            biu_reg       <= '0;
            cur_reg       <= '0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            mode_reg      <= mode_next;
            counter_reg   <= counter_next;
            biu_reg       <= biu_next;
            cur_reg       <= cur_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg        <= size_next;
        too_big_reg     <= too_big_next;
        number_reg      <= number_next;
        pend_bin_reg    <= pend_bin_next;
        pend_open_reg   <= pend_open_next;
        pend_status_reg <= pend_status_next;
        out_number_reg  <= out_number_next;
        out_bin_reg     <= out_bin_next;
        out_open_reg    <= out_open_next;
        out_status_reg  <= out_status_next;
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign item_number  = out_number_reg;
    assign bin_index    = out_bin_reg;
    assign opened_bin   = out_open_reg;
    assign status       = out_status_reg;
    assign mode         = mode_reg;
    assign current_bin  = cur_reg;
    assign size         = size_reg;
    assign launch.valid = launch_reg;
    assign launch.found = 1'b0;

endmodule

`default_nettype wire

@@ design/online_bin_packing_placer.sv @@
// Top level of the online bin packing placer: controller plus a chain of MAX_BINS bin cells.
// Depends on obp_pkg, obp_ctrl and obp_cell.
//
//   channel   direction   handshake              beat contents
//   cfg       in          cfg_valid / cfg_ready  cfg_index, cfg_data
//   in        in          in_valid / in_ready    item_size, first_item
//   out       out         out_valid / out_ready  item_number, bin_index, opened_bin, status
//
// One item at a time: its search token walks the chain one bin cell per cycle; from the input beat
// the item passes the launch register, the bin cell registers, the pending result register and
// the output register, and the next input beat is taken only once the result is loaded there.
// A new item is taken as soon as the result is in the output register, even while it waits.
// Reset is asynchronous and active low; no clearing pass, bins are marked unused at once.
// cfg_ready is always high; a stalled output delays the next result register load and so the next input beat.
`default_nettype none

module online_bin_packing_placer
    import obp_pkg::*;
#(
    parameter int MAX_BINS   = 256,
    parameter int SIZE_WIDTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] item_size,
    input  wire logic        first_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      item_number,
    output logic [7:0]       bin_index,
    output logic             opened_bin,
    output logic [1:0]       status
);

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int BIU_W = $clog2(MAX_BINS + 1);

    logic [1:0]            mode;
    logic                  clear;
    logic [IDX_W-1:0]      current_bin;
    logic [SIZE_WIDTH-1:0] size;
    cmd_t                  cmd;
    logic [IDX_W-1:0]      cmd_idx;
    logic [SIZE_WIDTH-1:0] cmd_value;
    tok_t                  launch;

    tok_t                  tok   [0:MAX_BINS];
    logic [SIZE_WIDTH-1:0] left  [0:MAX_BINS];
    logic [IDX_W-1:0]      idx   [0:MAX_BINS];

    assign tok[0]  = launch;
    assign left[0] = '0;
    assign idx[0]  = '0;

    obp_ctrl #(
        .MAX_BINS   (MAX_BINS),
        .SIZE_WIDTH (SIZE_WIDTH),
        .IDX_W      (IDX_W),
        .BIU_W      (BIU_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .item_size   (item_size),
        .first_item  (first_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .item_number (item_number),
        .bin_index   (bin_index),
        .opened_bin  (opened_bin),
        .status      (status),
        .mode        (mode),
        .clear       (clear),
        .current_bin (current_bin),
        .size        (size),
        .launch      (launch),
        .cmd         (cmd),
        .cmd_idx     (cmd_idx),
        .cmd_value   (cmd_value),
        .chain_tok   (tok[MAX_BINS]),
        .chain_idx   (idx[MAX_BINS])
    );

    for (genvar g = 0; g < MAX_BINS; g++)
    begin : g_cell
        obp_cell #(
            .CELL_IDX   (g),
            .SIZE_WIDTH (SIZE_WIDTH),
            .IDX_W      (IDX_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .mode        (mode),
            .clear       (clear),
            .current_bin (current_bin),
            .size        (size),
            .cmd         (cmd),
            .cmd_idx     (cmd_idx),
            .cmd_value   (cmd_value),
            .tok_in      (tok[g]),
            .left_in     (left[g]),
            .idx_in      (idx[g]),
            .tok_out     (tok[g+1]),
            .left_out    (left[g+1]),
            .idx_out     (idx[g+1])
        );
    end

endmodule

`default_nettype wire

@@ design/obp_checker.sv @@
// Port-level checker for the online bin packing placer, bound to the top level.
// Depends on obp_pkg and online_bin_packing_placer.
`default_nettype none

module obp_checker
    import obp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] item_number,
    input wire logic [7:0]  bin_index,
    input wire logic        opened_bin,
    input wire logic [1:0]  status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_number) && $stable(bin_index)
            && $stable(opened_bin) && $stable(status))
        else $error("Stalled result beat changed.");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_PLACED) |-> (bin_index == 8'd0) && !opened_bin)
        else $error("Rejected item reports a bin.");

    a_open_placed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && opened_bin |-> status == STATUS_PLACED)
        else $error("Opened bin on a rejected item.");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Input taken again while an item is still being placed.");

endmodule

bind online_bin_packing_placer obp_checker u_obp_checker (.*);

`default_nettype wire

@@ tb/online_bin_packing_placer_test.sv @@
// Self-checking testbench for online_bin_packing_placer: first, best and next fit placement.
// A scoreboard class predicts every result beat; plain tasks drive items and registers.
// Depends on obp_pkg and the placer RTL only.
`timescale 1ns / 1ps

module online_bin_packing_placer_test;
    import obp_pkg::*;

    localparam int MAX_BINS = 256;
    localparam logic [1:0] FIT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1500;

    typedef struct {
        logic [15:0] number;
        logic [7:0]  bin;
        logic        opened;
        logic [1:0]  status;
    } placement_t;

    class placement_scoreboard;
        logic [15:0] residual [MAX_BINS];
        int unsigned bins_open;
        int unsigned next_fit_bin;
        logic [15:0] seq_number;
        logic [15:0] capacity;
        logic [1:0]  mode;
        placement_t  expected_q [$];
        int unsigned mismatches;

        function new();
            capacity     = CAPACITY_RESET;
            mode         = FIT_MODE_RESET;
            bins_open    = 0;
            next_fit_bin = 0;
            seq_number   = 16'd0;
            mismatches   = 0;
        endfunction

        function void set_register(input logic [7:0] idx, input logic [15:0] data);
            if (idx == CFG_BIN_CAPACITY)
                capacity = data;
            else if (idx == CFG_FIT_MODE)
                mode = data[1:0];
        endfunction

        function void record_item(input logic [15:0] size, input logic first);
            placement_t  p;
            int          chosen;
            int          b;
            logic [15:0] least;
            if (first)
            begin
                bins_open    = 0;
                next_fit_bin = 0;
                seq_number   = 16'd0;
            end
            p.number   = seq_number;
            seq_number = seq_number + 16'd1;
            p.bin      = 8'd0;
            p.opened   = 1'b0;
            p.status   = STATUS_PLACED;
            chosen     = -1;
            least      = 16'd0;
            if (size > capacity)
            begin
                p.status = STATUS_TOO_BIG;
            end
            else
            begin
                if (mode == FIT_NEXT)
                begin
                    if (next_fit_bin < bins_open && residual[next_fit_bin] >= size)
                        chosen = next_fit_bin;
                end
                else
                begin
                    // Best fit keeps the smallest leftover; first fit keeps the first hit.
                    for (b = 0; b < bins_open; b++)
                    begin
                        if (residual[b] >= size)
                        begin
                            if (chosen < 0 || (mode == FIT_BEST && residual[b] - size < least))
                            begin
                                chosen = b;
                                least  = residual[b] - size;
                            end
                        end
                    end
                end
                if (chosen >= 0)
                begin
                    residual[chosen] = residual[chosen] - size;
                    p.bin = 8'(chosen);
                end
                else if (bins_open >= MAX_BINS)
                begin
                    p.status = STATUS_NO_BIN;
                end
                else
                begin
                    residual[bins_open] = capacity - size;
                    p.bin    = 8'(bins_open);
                    p.opened = 1'b1;
                    if (mode == FIT_NEXT)
                        next_fit_bin = bins_open;
                    bins_open++;
                end
            end
            expected_q.insert(expected_q.size(), p);
        endfunction

        function void check_placement(input logic [15:0] number, input logic [7:0] bin,
                                      input logic opened, input logic [1:0] stat);
            placement_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: item %0d bin %0d opened %0b status %0d",
                             number, bin, opened, stat);
                return;
            end
            want = expected_q.pop_front();
            if (number !== want.number || bin !== want.bin || opened !== want.opened ||
                stat !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch item/bin/opened/status: expected %0d/%0d/%0b/%0d got %0d/%0d/%0b/%0d",
                             want.number, want.bin, want.opened, want.status,
                             number, bin, opened, stat);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'd0;
    logic [15:0] cfg_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] item_size = 16'd0;
    logic        first_item = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] item_number;
    logic [7:0]  bin_index;
    logic        opened_bin;
    logic [1:0]  status;

    placement_scoreboard sb = new();
    bit calm = 1'b0;
    int stall_left = 0;
    int random_sent = 0;

    online_bin_packing_placer #(
        .MAX_BINS   (MAX_BINS),
        .SIZE_WIDTH (16)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .item_size   (item_size),
        .first_item  (first_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .item_number (item_number),
        .bin_index   (bin_index),
        .opened_bin  (opened_bin),
        .status      (status)
    );

    always #6 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(12, 60);
    endfunction

    function automatic logic [15:0] pick_size();
        int cap;
        int r;
        cap = sb.capacity;
        r   = $urandom_range(0, 19);
        if (r == 0 && cap < 65535)
            return 16'($urandom_range(cap + 1, 65535));
        else if (r == 1)
            return 16'($urandom_range(0, 65535));
        else if (r < 10)
            return 16'($urandom_range(0, cap));
        else
            return 16'($urandom_range(0, cap / 3));
    endfunction

    function automatic logic [15:0] pick_capacity();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'd0;
        else if (r == 1)
            return 16'd1;
        else if (r == 2)
            return 16'hFFFF;
        else if (r < 6)
            return 16'($urandom_range(2, 16));
        else
            return 16'($urandom_range(17, 5000));
    endfunction

    // Check each result beat and draw the next stall.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_placement(item_number, bin_index, opened_bin, status);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                stall_left <= pick_gap();
        end
    end

    task automatic send_item(input logic [15:0] size, input logic first);
        int gap;
    begin
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        item_size  <= size;
        first_item <= first;
        do @(posedge clk); while (!in_ready);
        sb.record_item(size, first);
    end
    endtask

    task automatic drain_results();
    begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    end
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
    begin
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    end
    endtask

    task automatic configure(input logic [15:0] cap, input logic [1:0] mode);
    begin
        drain_results();
        write_reg(CFG_BIN_CAPACITY, cap);
        write_reg(CFG_FIT_MODE, {14'd0, mode});
    end
    endtask

    initial
    begin
        int k;
        int seq_len;
        logic first;
        logic [1:0] mode;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: capacity 100, best fit, with ties and oversized items.
        send_item(16'd60, 1'b1);
        send_item(16'd30, 1'b0);
        send_item(16'd50, 1'b0);
        send_item(16'd40, 1'b0);
        send_item(16'd10, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'd101, 1'b0);
        send_item(16'd100, 1'b0);
        send_item(16'd0, 1'b0);

        configure(16'hFFFF, FIT_FIRST);
        send_item(16'hFFFF, 1'b1);
        send_item(16'd32768, 1'b0);
        send_item(16'd32767, 1'b0);
        send_item(16'd1, 1'b0);
        send_item(16'd0, 1'b0);

        // Capacity and mode change in the middle of a sequence.
        configure(16'd10, FIT_NEXT);
        send_item(16'd3, 1'b0);
        send_item(16'd8, 1'b0);
        send_item(16'd2, 1'b0);
        send_item(16'd11, 1'b0);

        configure(16'd0, FIT_UNUSED);
        send_item(16'd0, 1'b1);
        send_item(16'd1, 1'b0);
        send_item(16'd0, 1'b0);

        // Open every bin, then run out of bins.
        configure(16'd1, 2'($urandom_range(0, 2)));
        send_item(16'd1, 1'b1);
        for (k = 0; k < MAX_BINS + 3; k++)
            send_item(16'd1, 1'b0);
        send_item(16'd2, 1'b0);
        send_item(16'd0, 1'b0);

        while (random_sent < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) != 0)
            begin
                mode = ($urandom_range(0, 9) == 0) ? FIT_UNUSED : 2'($urandom_range(0, 2));
                configure(pick_capacity(), mode);
            end
            seq_len = $urandom_range(4, 40);
            for (k = 0; k < seq_len; k++)
            begin
                if (k == 0)
                    first = ($urandom_range(0, 9) != 0);
                else
                    first = ($urandom_range(0, 49) == 0);
                send_item(pick_size(), first);
                random_sent++;
            end
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (MAX_BINS + 20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #(50_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
